FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rmth_pkg.sv
`default_nettype none
package rmth_pkg;
    localparam int DefCapacity   = 1024;
    localparam int DefValueWidth = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_REP_RD,
        ST_REP_CMP,
        ST_TOPS_RD,
        ST_TOPS_WAIT,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/core/rmth_ram.sv
`default_nettype none
module rmth_ram #(
    parameter int Width = 32,
    parameter int Depth = 512
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/running_median_two_heaps.sv
// Channel  | Dir | tdata (low bit first)                       | tuser
// s_axis   | in  | sample[31:0]                                | -
// m_axis   | out | median_floor[31:0], median_half, dropped     | -
//
// One word is processed at a time: the push target is decided, the pushed
// value is sifted up, any replace-top value is sifted down (left child read,
// then right), and both heap tops are read before the result is formed. The
// heap memories have registered reads, with one read per node visited.
// Reset clears only the counts, the held tops, the result valid and the state.
// The result register holds until taken; input stalls until the block is idle
// and the last result has been taken.
`default_nettype none
`include "assert_macros.svh"
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int CAPACITY    = DefCapacity,
    parameter int VALUE_WIDTH = DefValueWidth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // sample[31:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // median_floor[31:0], median_half, dropped, 0
);
    localparam int LoDepth = (CAPACITY + 1) / 2;
    localparam int AW      = $clog2(LoDepth) < 1 ? 1 : $clog2(LoDepth);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int VW      = VALUE_WIDTH;

    // Heaps are kept as max-heaps of VW+1 bit values; upper holds negations.
    localparam int HW = VW + 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_lo_cnt, n_lo_cnt, r_up_cnt, n_up_cnt;
    logic signed [HW-1:0] r_x, n_x;          // value being sifted
    logic signed [HW-1:0] r_sample, n_sample;
    logic [AW:0] r_idx, n_idx;               // current node
    logic r_heap, n_heap;                    // 0 lower, 1 upper
    logic r_rep_pend, n_rep_pend;            // replace-top after push
    logic signed [HW-1:0] r_rep_val, n_rep_val;
    logic r_rep_heap, n_rep_heap;
    logic signed [HW-1:0] r_lo_top, n_lo_top, r_up_top, n_up_top;
    logic r_drop, n_drop;
    logic [1:0] r_phase, n_phase;            // replace-top child reads
    logic signed [HW-1:0] r_cl, n_cl;
    logic [39:0] r_out, n_out;
    logic r_ovalid, n_ovalid;

    logic we_lo, we_up;
    logic [AW-1:0] wa_lo, wa_up, ra;
    logic signed [HW-1:0] wd;
    logic [HW-1:0] rd_lo, rd_up;
    logic signed [HW-1:0] rd;

    rmth_ram #(.Width(HW), .Depth(LoDepth)) u_lo (
        .i_clk(i_clk), .i_we(we_lo), .i_waddr(wa_lo), .i_wdata(wd),
        .i_raddr(ra), .o_rdata(rd_lo));
    rmth_ram #(.Width(HW), .Depth(1 << AW)) u_up (
        .i_clk(i_clk), .i_we(we_up), .i_waddr(wa_up), .i_wdata(wd),
        .i_raddr(ra), .o_rdata(rd_up));

    logic [CW-1:0] cnt_sel;
    logic [AW:0] par_idx, lc_idx;
    logic signed [HW:0] sum;

    assign rd      = r_heap ? $signed(rd_up) : $signed(rd_lo);
    assign cnt_sel = r_heap ? r_up_cnt : r_lo_cnt;
    assign par_idx = (r_idx - 1'b1) >> 1;
    assign lc_idx  = {r_idx[AW-1:0], 1'b1};
    assign sum     = {r_lo_top[HW-1], r_lo_top} - {r_up_top[HW-1], r_up_top};

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_lo_cnt <= '0;
            r_up_cnt <= '0;
            r_ovalid <= 1'b0;
            r_lo_top <= '0;
            r_up_top <= '0;
        end else begin
            r_state  <= n_state;
            r_lo_cnt <= n_lo_cnt;
            r_up_cnt <= n_up_cnt;
            r_ovalid <= n_ovalid;
            r_lo_top <= n_lo_top;
            r_up_top <= n_up_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_sample   <= n_sample;
        r_idx      <= n_idx;
        r_heap     <= n_heap;
        r_rep_pend <= n_rep_pend;
        r_rep_val  <= n_rep_val;
        r_rep_heap <= n_rep_heap;
        r_drop     <= n_drop;
        r_phase    <= n_phase;
        r_cl       <= n_cl;
        r_out      <= n_out;
    end

    always_comb begin
        n_state = r_state; n_lo_cnt = r_lo_cnt; n_up_cnt = r_up_cnt;
        n_x = r_x; n_sample = r_sample; n_idx = r_idx; n_heap = r_heap;
        n_rep_pend = r_rep_pend; n_rep_val = r_rep_val; n_rep_heap = r_rep_heap;
        n_lo_top = r_lo_top; n_up_top = r_up_top; n_drop = r_drop;
        n_phase = r_phase; n_cl = r_cl; n_out = r_out; n_ovalid = r_ovalid;
        we_lo = 1'b0; we_up = 1'b0; wa_lo = r_idx[AW-1:0]; wa_up = r_idx[AW-1:0];
        wd = r_x; ra = '0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_sample = HW'($signed(s_axis_tdata[VW-1:0]));
                    n_drop   = (CW+1)'(r_lo_cnt) + (CW+1)'(r_up_cnt) >= (CW+1)'(CAPACITY);
                    n_rep_pend = 1'b0;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // Choose push target and any replace-top, or go to the top reads on a drop (tops held in registers).
                n_state = ST_PUSH_CMP;
                if (r_drop) begin
                    n_state = ST_TOPS_RD;
                end else if (r_lo_cnt == '0 || r_sample <= r_lo_top) begin
                    if (r_lo_cnt == r_up_cnt) begin
                        n_heap = 1'b0; n_x = r_sample;
                    end else begin
                        n_heap = 1'b1; n_x = -r_lo_top;
                        n_rep_pend = 1'b1; n_rep_heap = 1'b0; n_rep_val = r_sample;
                    end
                end else if (r_lo_cnt != r_up_cnt) begin
                    n_heap = 1'b1; n_x = -r_sample;
                end else if (r_up_cnt == '0 || r_sample <= -r_up_top) begin
                    n_heap = 1'b0; n_x = r_sample;
                end else begin
                    n_heap = 1'b0; n_x = -r_up_top;
                    n_rep_pend = 1'b1; n_rep_heap = 1'b1; n_rep_val = -r_sample;
                end
                if (!r_drop) begin
                    n_idx = (AW+1)'(n_heap ? r_up_cnt : r_lo_cnt);
                    if (n_heap) n_up_cnt = r_up_cnt + 1'b1;
                    else        n_lo_cnt = r_lo_cnt + 1'b1;
                    n_state = ST_PUSH_RD;
                end
            end
            ST_PUSH_RD: begin
                // Sift up: read the parent, or write at the root.
                if (r_idx == '0) begin
                    we_lo = !r_heap; we_up = r_heap;
                    n_state = r_rep_pend ? ST_REP_RD : ST_TOPS_RD;
                    if (r_rep_pend) begin
                        n_heap = r_rep_heap; n_x = r_rep_val; n_idx = '0;
                        n_phase = 2'd0; n_rep_pend = 1'b0;
                    end
                end else begin
                    ra = par_idx[AW-1:0];
                    n_state = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP: begin
                if (rd >= r_x) begin
                    we_lo = !r_heap; we_up = r_heap;
                    n_state = r_rep_pend ? ST_REP_RD : ST_TOPS_RD;
                    if (r_rep_pend) begin
                        n_heap = r_rep_heap; n_x = r_rep_val; n_idx = '0;
                        n_phase = 2'd0; n_rep_pend = 1'b0;
                    end
                end else begin
                    // Move parent down one level.
                    we_lo = !r_heap; we_up = r_heap; wd = rd;
                    n_idx = par_idx;
                    n_state = ST_PUSH_RD;
                end
            end
            ST_REP_RD: begin
                // Sift down: read left then, if present, right child, or write at a leaf.
                if ((CW+1)'(lc_idx) >= (CW+1)'(cnt_sel)) begin
                    we_lo = !r_heap; we_up = r_heap;
                    n_state = ST_TOPS_RD;
                end else begin
                    ra = r_phase[0] ? AW'(lc_idx + 1'b1) : lc_idx[AW-1:0];
                    n_state = ST_REP_CMP;
                end
            end
            ST_REP_CMP: begin
                if (r_phase == 2'd0) begin
                    n_cl = rd; n_phase = 2'd1;
                    n_state = ((CW+1)'(lc_idx) + 1'b1 < (CW+1)'(cnt_sel)) ? ST_REP_RD
                                                                         : ST_REP_CMP;
                    if (n_state == ST_REP_CMP) n_phase = 2'd2;
                end else begin
                    // Both children known when phase 1, only left when phase 2.
                    if (r_phase == 2'd1 && rd > r_cl && rd > r_x) begin
                        we_lo = !r_heap; we_up = r_heap; wd = rd;
                        n_idx = lc_idx + 1'b1; n_phase = 2'd0; n_state = ST_REP_RD;
                    end else if (r_cl > r_x) begin
                        we_lo = !r_heap; we_up = r_heap; wd = r_cl;
                        n_idx = lc_idx; n_phase = 2'd0; n_state = ST_REP_RD;
                    end else begin
                        we_lo = !r_heap; we_up = r_heap;
                        n_state = ST_TOPS_RD;
                    end
                end
            end
            ST_TOPS_RD: begin
                ra = '0; n_heap = 1'b0; n_state = ST_TOPS_WAIT;
            end
            ST_TOPS_WAIT: begin
                n_lo_top = $signed(rd_lo); n_up_top = $signed(rd_up);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (r_lo_cnt == '0) begin
                    n_out = {6'd0, r_drop, 1'b0, 32'd0};
                end else if (r_lo_cnt == r_up_cnt) begin
                    n_out = {6'd0, r_drop, sum[0], 32'($signed(sum[HW:1]))};
                end else begin
                    n_out = {6'd0, r_drop, 1'b0, 32'(r_lo_top)};
                end
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_balance, i_clk, i_rst_n, r_state == ST_IDLE, (r_lo_cnt == r_up_cnt) || (r_lo_cnt == r_up_cnt + 1'b1), "heap counts out of balance")
    `ASSERT_IMPL(a_cap, i_clk, i_rst_n, 1'b1, (CW+1)'(r_lo_cnt) + (CW+1)'(r_up_cnt) <= (CW+1)'(CAPACITY), "store overfilled")
    `ASSERT_NEXT(a_out, i_clk, i_rst_n, r_state == ST_OUT, r_ovalid, "result not raised")
endmodule
`default_nettype wire

FILE: verif/running_median_two_heaps_tb.sv
`timescale 1ns / 1ps

module running_median_two_heaps_tb;

    localparam int Capacity = 1024;
    localparam int LowerDepth = (Capacity + 1) / 2;
    localparam int UpperDepth = Capacity / 2;
    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles = 200;

    typedef struct packed {
        logic        dropped;
        logic        median_half;
        logic [31:0] median_floor;
    } median_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // sample[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // median_floor[31:0], median_half, dropped, 0

    running_median_two_heaps u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state: lower half as a max-heap, upper half as a min-heap
    // stored negated so both are max-heaps of 64-bit values.
    longint lower_heap[];
    longint upper_heap[];
    int     lower_cnt;
    int     upper_cnt;

    median_t expected_medians[$];
    int      error_count;
    int      words_sent;
    int      words_checked;
    int      drops_seen;
    int      idle_cycles;
    bit      sender_idles;
    bit      receiver_idles;
    bit      hold_receiver;
    bit      timed_out;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void heap_push(ref longint h[], ref int n, input int depth,
                                      input longint v);
        int     i;
        int     p;
        longint t;
        if (n >= depth) return;
        i = n;
        h[i] = v;
        n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (h[p] >= h[i]) break;
            t = h[p]; h[p] = h[i]; h[i] = t;
            i = p;
        end
    endfunction

    function automatic void heap_replace_top(ref longint h[], input int n, input longint v);
        int     i;
        int     l;
        int     big;
        longint t;
        if (n == 0) return;
        i = 0;
        h[0] = v;
        forever begin
            l = 2 * i + 1;
            big = i;
            if (l < n && h[l] > h[big]) big = l;
            if (l + 1 < n && h[l + 1] > h[big]) big = l + 1;
            if (big == i) break;
            t = h[big]; h[big] = h[i]; h[i] = t;
            i = big;
        end
    endfunction

    // Fold a sample into the halves and work out the median it produces.
    function automatic median_t predict_median(logic [31:0] sample);
        median_t r;
        longint  x;
        longint  s;
        bit      balanced;
        r = '0;
        x = longint'(signed'(sample));
        if (lower_cnt + upper_cnt >= Capacity) begin
            r.dropped = 1'b1;
        end else begin
            balanced = (lower_cnt == upper_cnt);
            if (lower_cnt == 0 || x <= lower_heap[0]) begin
                if (balanced) begin
                    heap_push(lower_heap, lower_cnt, LowerDepth, x);
                end else begin
                    heap_push(upper_heap, upper_cnt, UpperDepth, -lower_heap[0]);
                    heap_replace_top(lower_heap, lower_cnt, x);
                end
            end else if (!balanced) begin
                heap_push(upper_heap, upper_cnt, UpperDepth, -x);
            end else if (upper_cnt == 0 || x <= -upper_heap[0]) begin
                heap_push(lower_heap, lower_cnt, LowerDepth, x);
            end else begin
                heap_push(lower_heap, lower_cnt, LowerDepth, -upper_heap[0]);
                heap_replace_top(upper_heap, upper_cnt, -x);
            end
        end
        if (lower_cnt == upper_cnt && lower_cnt != 0) begin
            s = lower_heap[0] - upper_heap[0];
            r.median_half = s[0];
            r.median_floor = s[32:1];
        end else if (lower_cnt != 0) begin
            r.median_floor = lower_heap[0][31:0];
        end
        return r;
    endfunction

    // Offer one word, idling first at random when allowed.
    task automatic send_sample(logic [31:0] sample);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = sample;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_medians.push_back(predict_median(sample));
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_medians.size() != 0 && !timed_out) @(negedge i_clk);
    endtask

    // A fresh stream needs a reset, which clears the heap counts; keep the
    // single stream going and fill to capacity once near the end instead.
    task automatic test_directed();
        logic [31:0] edge_vals[12];
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h1, 32'h1, 32'h8000_0001, 32'h7FFF_FFFE,
                      32'h0000_0003, 32'hFFFF_FFFC};
        foreach (edge_vals[i]) send_sample(edge_vals[i]);
        wait_drained();
    endtask

    task automatic test_random_values(int n);
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom_range(0, 40) - 20;
                2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
                default: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            endcase
            send_sample(v);
        end
    endtask

    // Stall the output for a long stretch while the input keeps offering words.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            test_random_values(20);
        join
        wait_drained();
    endtask

    // Fill the store past capacity so that further words are dropped.
    task automatic test_store_full();
        test_random_values(Capacity - lower_cnt - upper_cnt + 200);
        wait_drained();
    endtask

    task automatic test_no_idling();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random_values(280);
        wait_drained();
    endtask

    // Receiver: take results, idle in bursts, hold off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                m_axis_tready <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        median_t got;
        median_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[33:0];
            if (expected_medians.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_medians.pop_front();
                words_checked++;
                if (want.dropped) drops_seen++;
                if (got.median_floor !== want.median_floor) begin
                    $error("median_floor exp %0d got %0d", $signed(want.median_floor),
                           $signed(got.median_floor));
                    error_count++;
                end
                if (got.median_half !== want.median_half) begin
                    $error("median_half exp %0d got %0d", want.median_half, got.median_half);
                    error_count++;
                end
                if (got.dropped !== want.dropped) begin
                    $error("dropped exp %0d got %0d", want.dropped, got.dropped);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles without any accepted word on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        lower_heap = new[LowerDepth];
        upper_heap = new[UpperDepth];
        lower_cnt = 0;
        upper_cnt = 0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        drops_seen = 0;
        idle_cycles = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        hold_receiver = 1'b0;
        timed_out = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        fork
            begin
                test_directed();
                test_random_values(300);
                test_backpressure();
                test_random_values(200);
                test_store_full();
                test_no_idling();
                repeat (SettleCycles) @(negedge i_clk);
            end
            begin
                wait (idle_cycles >= WatchdogLimit);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            $display("Streamed %0d samples (%0d checked, %0d dropped once full),",
                     words_sent, words_checked, drops_seen);
            $display("with edge values, output stalls and idle bursts on both sides.");
            if (error_count == 0 && expected_medians.size() == 0) begin
                $display("TB_OK");
            end else begin
                $display("TB_ERROR");
            end
            $finish;
        end
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rmth_pkg.sv
rtl/core/rmth_ram.sv
rtl/core/running_median_two_heaps.sv
verif/running_median_two_heaps_tb.sv
